// ===== hdl/spk_pkg.sv =====
// Shared types, widths and constants of the spectral peak picker.
package spk_pkg;

    localparam int FFT_LEN_DEF   = 1024;
    localparam int TOP_PEAKS_DEF = 5;

    localparam int IN_W   = 27;          // signed bin component
    localparam int SQ_W   = 2 * IN_W;    // square and sum of squares
    localparam int POW_W  = 44;          // power after the divide
    localparam int LEV_W  = 45;          // smoothed level
    localparam int LVL_W  = 38;          // stored level (level >> 7)
    localparam int BIN_W  = 9;

    localparam int KEEP_SHIFT = 6;
    localparam int LVL_SHIFT  = 7;

    // Divide by 1000, one 16-bit chunk per pipeline stage
    localparam int DIVISOR     = 1000;
    localparam int CHUNK_W     = 16;
    localparam int N_CHUNK     = (SQ_W + CHUNK_W - 1) / CHUNK_W;
    localparam int REM_W       = 10;
    localparam int RECIP_SHIFT = 36;
    localparam longint RECIP   = (longint'(1) << RECIP_SHIFT) / DIVISOR;
    localparam int RECIP_W     = 27;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_MIN_BIN = 1'b0;   // word index of min_bin
    localparam logic [BIN_W-1:0] MIN_BIN_RESET = 9'd51;

    typedef logic signed [IN_W-1:0] sample_t;
    typedef logic [BIN_W-1:0]       bin_t;
    typedef logic [LVL_W-1:0]       lvl_t;
    typedef logic [POW_W-1:0]       pow_t;
    typedef logic [LEV_W-1:0]       lev_t;

    typedef struct packed {
        logic valid;
        logic frame_end;
        pow_t power;
    } pow_item_t;

    typedef struct packed {
        logic en;
        bin_t bin;
        lev_t left;
        lev_t mid;
        lev_t right;
    } cand_t;

endpackage

// ===== hdl/spk_if.sv =====
// Stream interfaces for incoming bins and outgoing ranked peaks.
interface spk_bin_if;
    logic             valid;
    logic             ready;
    spk_pkg::sample_t bin_real;
    spk_pkg::sample_t bin_imag;
    logic             frame_end;

    modport source (output valid, bin_real, bin_imag, frame_end, input ready);
    modport sink   (input valid, bin_real, bin_imag, frame_end, output ready);
endinterface

interface spk_peak_if;
    logic          valid;
    logic          ready;
    spk_pkg::bin_t peak_bin;
    spk_pkg::lvl_t peak_level;
    logic          peak_last;

    modport source (output valid, peak_bin, peak_level, peak_last, input ready);
    modport sink   (input valid, peak_bin, peak_level, peak_last, output ready);
endinterface

// ===== hdl/spk_power.sv =====
// Power pipeline: magnitude squares, sum, and chunked divide by 1000.
module spk_power
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  spk_pkg::sample_t   in_real,
    input  spk_pkg::sample_t   in_imag,
    input  logic               in_end,
    output spk_pkg::pow_item_t pow
);

    localparam int SQ_W  = spk_pkg::SQ_W;
    localparam int IN_W  = spk_pkg::IN_W;
    localparam int CW    = spk_pkg::CHUNK_W;
    localparam int NC    = spk_pkg::N_CHUNK;
    localparam int RW    = spk_pkg::REM_W;
    localparam int V_W   = RW + CW;
    localparam int PR_W  = V_W + spk_pkg::RECIP_W;
    localparam int QW    = CW * NC;

    logic [IN_W-1:0] mag_re;
    logic [IN_W-1:0] mag_im;
    logic [SQ_W-1:0] sq_re;
    logic [SQ_W-1:0] sq_im;

    logic            sq_v_reg;
    logic            sq_fe_reg;
    logic [SQ_W-1:0] sq_re_reg;
    logic [SQ_W-1:0] sq_im_reg;
    logic            sum_v_reg;
    logic            sum_fe_reg;
    logic [SQ_W-1:0] sum_reg;

    logic            d_v_reg   [NC];
    logic            d_fe_reg  [NC];
    logic [RW-1:0]   d_rem_reg [NC];
    logic [QW-1:0]   d_quo_reg [NC];
    logic [QW-1:0]   d_num_reg [NC];

    always_comb
    begin
        mag_re = in_real[IN_W-1] ? IN_W'(-in_real) : IN_W'(in_real);
        mag_im = in_imag[IN_W-1] ? IN_W'(-in_imag) : IN_W'(in_imag);
        sq_re  = mag_re * mag_re;
        sq_im  = mag_im * mag_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg  <= 1'b0;
            sum_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg  <= in_valid;
            sum_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_re_reg  <= sq_re;
            sq_im_reg  <= sq_im;
            sq_fe_reg  <= in_end;
            sum_reg    <= sq_re_reg + sq_im_reg;
            sum_fe_reg <= sq_fe_reg;
        end
    end

    // Long division by 1000, most significant chunk first
    for (genvar i = 0; i < NC; i++)
    begin : g_div
        logic [QW-1:0]   num_in;
        logic [RW-1:0]   rem_in;
        logic [QW-1:0]   quo_in;
        logic            v_in;
        logic            fe_in;
        logic [V_W-1:0]  part;
        logic [PR_W-1:0] prod;
        logic [CW-1:0]   q0;
        logic [V_W-1:0]  q0_times;
        logic [V_W-1:0]  r0;
        logic [CW-1:0]   q;
        logic [RW-1:0]   r;

        if (i == 0)
        begin : g_first
            assign num_in = QW'(sum_reg);
            assign rem_in = '0;
            assign quo_in = '0;
            assign v_in   = sum_v_reg;
            assign fe_in  = sum_fe_reg;
        end
        else
        begin : g_next
            assign num_in = d_num_reg[i-1];
            assign rem_in = d_rem_reg[i-1];
            assign quo_in = d_quo_reg[i-1];
            assign v_in   = d_v_reg[i-1];
            assign fe_in  = d_fe_reg[i-1];
        end

        always_comb
        begin
            part     = {rem_in, num_in[(NC-1-i)*CW +: CW]};
            prod     = PR_W'(part) * PR_W'(spk_pkg::RECIP);
            q0       = prod[spk_pkg::RECIP_SHIFT +: CW];
            // q0 * 1000 as shifts
            q0_times = (V_W'(q0) << 10) - (V_W'(q0) << 4) - (V_W'(q0) << 3);
            r0       = part - q0_times;
            if (r0 >= V_W'(spk_pkg::DIVISOR))
            begin
                q = q0 + CW'(1);
                r = RW'(r0 - V_W'(spk_pkg::DIVISOR));
            end
            else
            begin
                q = q0;
                r = RW'(r0);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_v_reg[i] <= 1'b0;
            else if (en)
                d_v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_fe_reg[i]  <= fe_in;
                d_rem_reg[i] <= r;
                d_quo_reg[i] <= {quo_in[QW-CW-1:0], q};
                d_num_reg[i] <= num_in;
            end
        end
    end

    assign pow.valid     = d_v_reg[NC-1];
    assign pow.frame_end = d_fe_reg[NC-1];
    assign pow.power     = d_quo_reg[NC-1][spk_pkg::POW_W-1:0];

endmodule

// ===== hdl/spk_insert.sv =====
// Top-k list insertion of one peak candidate, ties placed after equal entries.
module spk_insert
#(
    parameter int TOP_PEAKS = spk_pkg::TOP_PEAKS_DEF
)
(
    input  spk_pkg::cand_t cand,
    input  spk_pkg::lvl_t  lvl_in  [TOP_PEAKS],
    input  spk_pkg::bin_t  bin_in  [TOP_PEAKS],
    output spk_pkg::lvl_t  lvl_out [TOP_PEAKS],
    output spk_pkg::bin_t  bin_out [TOP_PEAKS]
);

    localparam int LEV_W = spk_pkg::LEV_W;
    localparam int LVL_W = spk_pkg::LVL_W;

    logic                 take;
    spk_pkg::lvl_t        lvl_new;
    logic [TOP_PEAKS-1:0] ge;

    assign lvl_new = LVL_W'(cand.mid >> spk_pkg::LVL_SHIFT);
    assign take    = cand.en
                   && ((cand.mid >> spk_pkg::KEEP_SHIFT) > LEV_W'(lvl_in[TOP_PEAKS-1]))
                   && (cand.mid >= cand.left)
                   && (cand.mid > cand.right);

    for (genvar j = 0; j < TOP_PEAKS; j++)
    begin : g_slot
        logic keep;

        assign ge[j] = lvl_in[j] >= lvl_new;
        assign keep  = (j < TOP_PEAKS - 1) && ge[j];

        if (j == 0)
        begin : g_head
            always_comb
            begin
                if (!take || keep)
                begin
                    lvl_out[j] = lvl_in[j];
                    bin_out[j] = bin_in[j];
                end
                else
                begin
                    lvl_out[j] = lvl_new;
                    bin_out[j] = cand.bin;
                end
            end
        end
        else
        begin : g_body
            logic put;

            assign put = ge[j-1];
            always_comb
            begin
                if (!take || keep)
                begin
                    lvl_out[j] = lvl_in[j];
                    bin_out[j] = bin_in[j];
                end
                else if (put)
                begin
                    lvl_out[j] = lvl_new;
                    bin_out[j] = cand.bin;
                end
                else
                begin
                    // shift down behind the new entry
                    lvl_out[j] = lvl_in[j-1];
                    bin_out[j] = bin_in[j-1];
                end
            end
        end
    end

endmodule

// ===== hdl/spectrum_top_peak_picker.sv =====
// Spectral peak picker top level: power pipeline, peak test, top-k list, output buffer.
//
//   port       dir  kind       content
//   bin_in     in   stream     bin_real, bin_imag, frame_end (one FFT bin per item)
//   peak_out   out  stream     peak_bin, peak_level, peak_last (TOP_PEAKS items per frame)
//   psel..     in   APB        min_bin at word 0
//
// One bin is accepted per cycle unless the pipeline is held; a bin reaches the peak test
// through the input register, square, sum and four divide-by-1000 chunk stages.
// The frame's last bin copies the ranked list into an output buffer that drains one item
// per cycle if peak_out is ready; a further frame end at the peak test while the buffer still
// drains holds the whole pipeline, so frames shorter than TOP_PEAKS+1 bins slow intake.
// Reset clears all frame state at once and loads min_bin with 51.
// peak_out stalls never drop an item; bin_in ready drops only during that hold.
module spectrum_top_peak_picker
#(
    parameter int FFT_LEN   = spk_pkg::FFT_LEN_DEF,
    parameter int TOP_PEAKS = spk_pkg::TOP_PEAKS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    spk_bin_if.sink                        bin_in,
    spk_peak_if.source                     peak_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spk_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spk_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [spk_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int KW       = $clog2(FFT_LEN / 2);
    localparam int CW       = (KW > spk_pkg::BIN_W) ? KW : spk_pkg::BIN_W;
    localparam int LAST_BIN = FFT_LEN / 2 - 1;
    localparam int CNT_W    = $clog2(TOP_PEAKS + 1);
    localparam int LEV_W    = spk_pkg::LEV_W;
    localparam int BIN_W    = spk_pkg::BIN_W;

    // configuration
    logic                  cfg_write;
    spk_pkg::bin_t         min_bin_reg;

    // input register
    logic                  in_v_reg;
    spk_pkg::sample_t      in_re_reg;
    spk_pkg::sample_t      in_im_reg;
    logic                  in_fe_reg;

    logic                  en;
    logic                  stall;
    spk_pkg::pow_item_t    pow;

    // frame state
    spk_pkg::pow_t         pw0_reg, pw1_reg, pw2_reg;
    spk_pkg::lev_t         lw0_reg, lw1_reg;
    logic [KW-1:0]         k_reg;
    spk_pkg::lvl_t         tl_reg [TOP_PEAKS];
    spk_pkg::bin_t         tb_reg [TOP_PEAKS];

    // peak test
    logic                  fire;
    logic                  last;
    spk_pkg::lev_t         lev_mid;
    spk_pkg::lev_t         lev_end;
    logic [CW-1:0]         bin1_c;
    logic [CW-1:0]         bin2_c;
    spk_pkg::cand_t        cand1;
    spk_pkg::cand_t        cand2;
    spk_pkg::lvl_t         tl1 [TOP_PEAKS];
    spk_pkg::bin_t         tb1 [TOP_PEAKS];
    spk_pkg::lvl_t         tl2 [TOP_PEAKS];
    spk_pkg::bin_t         tb2 [TOP_PEAKS];

    // output buffer
    logic [CNT_W-1:0]      cnt_reg;
    spk_pkg::lvl_t         ob_lvl_reg [TOP_PEAKS];
    spk_pkg::bin_t         ob_bin_reg [TOP_PEAKS];
    logic                  out_take;

    // ---------------- configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[spk_pkg::CFG_ADDR_W-1] == spk_pkg::REG_MIN_BIN)
            prdata = spk_pkg::CFG_DATA_W'(min_bin_reg);
        else
            prdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_bin_reg <= spk_pkg::MIN_BIN_RESET;
        else if (cfg_write && paddr[spk_pkg::CFG_ADDR_W-1] == spk_pkg::REG_MIN_BIN)
            min_bin_reg <= pwdata[BIN_W-1:0];
    end

    // ---------------- input register and power pipeline
    assign last  = pow.frame_end || (k_reg >= KW'(LAST_BIN));
    assign stall = pow.valid && last && (cnt_reg != '0);
    assign en    = !stall;
    assign fire  = pow.valid && en;

    assign bin_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (en)
            in_v_reg <= bin_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_re_reg <= bin_in.bin_real;
            in_im_reg <= bin_in.bin_imag;
            in_fe_reg <= bin_in.frame_end;
        end
    end

    spk_power u_power
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_v_reg),
        .in_real  (in_re_reg),
        .in_imag  (in_im_reg),
        .in_end   (in_fe_reg),
        .pow      (pow)
    );

    // ---------------- peak test on bin k-2, and on bin k-1 at frame end
    always_comb
    begin
        lev_mid = LEV_W'(pw2_reg)
                + ((LEV_W'(pw1_reg) + LEV_W'(pow.power)) >> 1);
        lev_end = (LEV_W'(pw2_reg) >> 1) + LEV_W'(pow.power);
        bin1_c  = CW'(k_reg - KW'(2));
        bin2_c  = CW'(k_reg - KW'(1));

        cand1.en    = (k_reg >= KW'(2)) && (bin1_c >= CW'(min_bin_reg));
        cand1.bin   = bin1_c[BIN_W-1:0];
        cand1.left  = lw0_reg;
        cand1.mid   = lw1_reg;
        cand1.right = lev_mid;

        cand2.en    = last && (bin2_c >= CW'(min_bin_reg));
        cand2.bin   = bin2_c[BIN_W-1:0];
        cand2.left  = lw1_reg;
        cand2.mid   = lev_mid;
        cand2.right = lev_end;
    end

    spk_insert #(.TOP_PEAKS(TOP_PEAKS)) u_ins_mid
    (
        .cand    (cand1),
        .lvl_in  (tl_reg),
        .bin_in  (tb_reg),
        .lvl_out (tl1),
        .bin_out (tb1)
    );

    spk_insert #(.TOP_PEAKS(TOP_PEAKS)) u_ins_end
    (
        .cand    (cand2),
        .lvl_in  (tl1),
        .bin_in  (tb1),
        .lvl_out (tl2),
        .bin_out (tb2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw0_reg <= '0;
            pw1_reg <= '0;
            pw2_reg <= '0;
            lw0_reg <= '0;
            lw1_reg <= '0;
            k_reg   <= KW'(1);
            for (int j = 0; j < TOP_PEAKS; j++)
            begin
                tl_reg[j] <= '0;
                tb_reg[j] <= '0;
            end
        end
        else if (fire)
        begin
            if (last)
            begin
                // frame done: back to the empty state
                pw0_reg <= '0;
                pw1_reg <= '0;
                pw2_reg <= '0;
                lw0_reg <= '0;
                lw1_reg <= '0;
                k_reg   <= KW'(1);
                for (int j = 0; j < TOP_PEAKS; j++)
                begin
                    tl_reg[j] <= '0;
                    tb_reg[j] <= '0;
                end
            end
            else
            begin
                pw0_reg <= pw1_reg;
                pw1_reg <= pw2_reg;
                pw2_reg <= pow.power;
                lw0_reg <= lw1_reg;
                lw1_reg <= lev_mid;
                k_reg   <= k_reg + KW'(1);
                for (int j = 0; j < TOP_PEAKS; j++)
                begin
                    tl_reg[j] <= tl2[j];
                    tb_reg[j] <= tb2[j];
                end
            end
        end
    end

    // ---------------- output buffer, drained from slot 0
    assign out_take = peak_out.valid && peak_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (fire && last)
            cnt_reg <= CNT_W'(TOP_PEAKS);
        else if (out_take)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (fire && last)
        begin
            for (int j = 0; j < TOP_PEAKS; j++)
            begin
                ob_lvl_reg[j] <= tl2[j];
                ob_bin_reg[j] <= tb2[j];
            end
        end
        else if (out_take)
        begin
            for (int j = 0; j < TOP_PEAKS - 1; j++)
            begin
                ob_lvl_reg[j] <= ob_lvl_reg[j+1];
                ob_bin_reg[j] <= ob_bin_reg[j+1];
            end
        end
    end

    assign peak_out.valid      = cnt_reg != '0;
    assign peak_out.peak_bin   = ob_bin_reg[0];
    assign peak_out.peak_level = ob_lvl_reg[0];
    assign peak_out.peak_last  = cnt_reg == CNT_W'(1);

endmodule

// ===== hdl/spk_checker.sv =====
// Port-level checks of the peak picker, bound to the top level.
module spk_checker
#(
    parameter int TOP_PEAKS = spk_pkg::TOP_PEAKS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input spk_pkg::bin_t peak_bin,
    input spk_pkg::lvl_t peak_level,
    input logic          peak_last
);

    localparam int CNT_W = $clog2(TOP_PEAKS + 1);

    logic [CNT_W-1:0] pos_reg;
    spk_pkg::lvl_t    prev_lvl_reg;
    logic             out_take;

    assign out_take = out_valid && out_ready;

    // position of the next item inside the frame's ranked list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (out_take)
            pos_reg <= peak_last ? '0 : pos_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
            prev_lvl_reg <= peak_level;
    end

    a_quiet_in_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("peak output valid during reset");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(peak_bin)
                                    && $stable(peak_level) && $stable(peak_last))
        else $error("stalled peak item changed");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (peak_last == (pos_reg == CNT_W'(TOP_PEAKS - 1))))
        else $error("peak_last not on the final ranked slot");

    a_ranked: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && (pos_reg != '0) |-> peak_level <= prev_lvl_reg)
        else $error("peak levels not in descending order");

endmodule

bind spectrum_top_peak_picker spk_checker #(.TOP_PEAKS(TOP_PEAKS)) u_spk_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (peak_out.valid),
    .out_ready  (peak_out.ready),
    .peak_bin   (peak_out.peak_bin),
    .peak_level (peak_out.peak_level),
    .peak_last  (peak_out.peak_last)
);

// ===== tb/testbench.sv =====
// Self-checking bench for the spectral peak picker: predicted ranked peak lists vs. the peak stream.
module testbench;
    import spk_pkg::*;

    localparam int TOP_N        = TOP_PEAKS_DEF;
    localparam int LAST_BIN     = FFT_LEN_DEF / 2 - 1;
    localparam int MAX_WAIT     = 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 16;     // per min_bin setting

    localparam logic [CFG_ADDR_W-1:0] MIN_BIN_ADDR = CFG_ADDR_W'(4 * REG_MIN_BIN);
    localparam sample_t SAMPLE_MAX = sample_t'((1 << (IN_W - 1)) - 1);
    localparam sample_t SAMPLE_MIN = sample_t'(1 << (IN_W - 1));

    typedef struct {
        bin_t bin;
        lvl_t level;
        logic last;
    } peak_rec_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    spk_bin_if  bin_in ();
    spk_peak_if peak_out ();

    spectrum_top_peak_picker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .bin_in   (bin_in),
        .peak_out (peak_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted frame state
    pow_t pow_hist [3];
    lev_t lev_hist [2];
    bin_t next_bin;
    lvl_t rank_level [TOP_N];
    bin_t rank_bin [TOP_N];
    bin_t min_bin_now;

    peak_rec_t   expected_peaks [$];
    int unsigned mismatch_count;
    int unsigned stall_left;
    int unsigned cycle_count;
    bit          send_burst;
    bit          sink_burst;

    function automatic void clear_frame_state();
        for (int i = 0; i < 3; i++)
            pow_hist[i] = '0;
        lev_hist[0] = '0;
        lev_hist[1] = '0;
        next_bin = bin_t'(1);
        for (int i = 0; i < TOP_N; i++)
        begin
            rank_level[i] = '0;
            rank_bin[i]   = '0;
        end
    endfunction

    function automatic pow_t power_of(sample_t re, sample_t im);
        logic [IN_W-1:0] mag_re;
        logic [IN_W-1:0] mag_im;
        logic [63:0]     energy;
        mag_re = re[IN_W-1] ? (~re + 1'b1) : re;
        mag_im = im[IN_W-1] ? (~im + 1'b1) : im;
        energy = 64'(mag_re) * 64'(mag_re) + 64'(mag_im) * 64'(mag_im);
        return pow_t'(energy / 64'(DIVISOR));
    endfunction

    // Keep a local maximum if it beats the lowest ranked entry; equal entries stay ahead
    function automatic void weigh_peak(bin_t bin, lev_t left, lev_t mid, lev_t right);
        int   slot;
        lvl_t lvl;
        lvl = lvl_t'(mid >> LVL_SHIFT);
        if (bin >= min_bin_now && (mid >> KEEP_SHIFT) > rank_level[TOP_N-1]
            && mid >= left && mid > right)
        begin
            slot = TOP_N - 1;
            while (slot > 0 && rank_level[slot-1] < lvl)
                slot--;
            for (int j = TOP_N - 1; j > slot; j--)
            begin
                rank_level[j] = rank_level[j-1];
                rank_bin[j]   = rank_bin[j-1];
            end
            rank_level[slot] = lvl;
            rank_bin[slot]   = bin;
        end
    endfunction

    function automatic void predict_bin(sample_t re, sample_t im, logic fe);
        bin_t k;
        logic ends;
        lev_t lev_new;
        k    = next_bin;
        ends = fe || (k >= LAST_BIN);
        pow_hist[0] = pow_hist[1];
        pow_hist[1] = pow_hist[2];
        pow_hist[2] = power_of(re, im);

        // level of bin k-1 is complete: test bin k-2
        lev_new = lev_t'(pow_hist[1]) + ((lev_t'(pow_hist[0]) + lev_t'(pow_hist[2])) >> 1);
        if (k >= 2)
            weigh_peak(k - bin_t'(2), lev_hist[0], lev_hist[1], lev_new);
        lev_hist[0] = lev_hist[1];
        lev_hist[1] = lev_new;

        if (!ends)
            next_bin = k + 1'b1;
        else
        begin
            lev_new = lev_t'(pow_hist[1] >> 1) + lev_t'(pow_hist[2]);
            weigh_peak(k - 1'b1, lev_hist[0], lev_hist[1], lev_new);
            for (int i = 0; i < TOP_N; i++)
                expected_peaks.push_back('{rank_bin[i], rank_level[i], i == TOP_N - 1});
            clear_frame_state();
        end
    endfunction

    task automatic send_bin(sample_t re, sample_t im, logic fe);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap != 0)
        begin
            bin_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        bin_in.valid     <= 1'b1;
        bin_in.bin_real  <= re;
        bin_in.bin_imag  <= im;
        bin_in.frame_end <= fe;
        @(posedge clk);
        while (!bin_in.ready)
            @(posedge clk);
        predict_bin(re, im, fe);
    endtask

    // Drop valid and wait until every ranked list has drained
    task automatic settle();
        @(negedge clk);
        bin_in.valid <= 1'b0;
        while (expected_peaks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_bin(bin_t value);
        settle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_BIN_ADDR;
        pwdata  <= {(CFG_DATA_W - BIN_W)'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        min_bin_now = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic sample_t draw_sample();
        int unsigned pick;
        int unsigned mag;
        sample_t     s;
        pick = $urandom_range(0, 9);
        case (pick)
            0: s = sample_t'($urandom);
            1: s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            2, 3, 4, 5:
            begin
                // a few fixed magnitudes so that equal levels turn up
                case ($urandom_range(0, 3))
                    0: mag = 300;
                    1: mag = 1000;
                    2: mag = 2000;
                    default: mag = 4000;
                endcase
                s = $urandom_range(0, 1) ? -sample_t'(mag) : sample_t'(mag);
            end
            6, 7: s = '0;
            default:
            begin
                mag = $urandom_range(0, 20000);
                s = $urandom_range(0, 1) ? -sample_t'(mag) : sample_t'(mag);
            end
        endcase
        return s;
    endfunction

    task automatic send_frame(int unsigned len);
        send_burst = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 1; i <= len; i++)
            send_bin(draw_sample(), draw_sample(), i == len);
    endtask

    task automatic test_one_bin_frame();
        write_min_bin(bin_t'(0));
        send_bin(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    endtask

    // With min_bin at 0, bin 0 is tested against a zero level on its left; bin 1 holds the peak
    task automatic test_left_of_zero();
        write_min_bin(bin_t'(0));
        send_bin(sample_t'(20000), '0, 1'b0);
        send_bin('0, '0, 1'b0);
        send_bin('0, '0, 1'b0);
        send_bin('0, '0, 1'b1);
    endtask

    task automatic test_extreme_values();
        write_min_bin(bin_t'(1));
        send_bin(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_bin(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_bin('0, '0, 1'b0);
        send_bin(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_bin('0, '0, 1'b1);
    endtask

    // Peaks on odd bins: ties, a new top entry and a drop off the end
    task automatic test_ranking_and_ties();
        int unsigned amp [7];
        sample_t     s;
        amp = '{1000, 1000, 3000, 1000, 5000, 2000, 1000};
        write_min_bin(bin_t'(1));
        for (int b = 1; b <= 14; b++)
        begin
            s = (b % 2 == 1) ? sample_t'(amp[b/2]) : sample_t'(0);
            send_bin(s, -s, b == 14);
        end
    endtask

    // No frame_end: the last bin index closes the frame on its own
    task automatic test_overlong_frame();
        write_min_bin(MIN_BIN_RESET);
        send_burst = 1'b1;
        sink_burst = 1'b0;
        for (int b = 1; b <= LAST_BIN; b++)
            send_bin(draw_sample(), draw_sample(), 1'b0);
        send_bin(draw_sample(), draw_sample(), 1'b0);
        send_bin(draw_sample(), draw_sample(), 1'b0);
        send_bin(draw_sample(), draw_sample(), 1'b1);
    endtask

    task automatic test_random_frames();
        bin_t        settings [5];
        int unsigned sent;
        int unsigned len;
        settings = '{bin_t'(0), bin_t'(511), bin_t'($urandom_range(2, 12)), bin_t'(1),
                     MIN_BIN_RESET};
        foreach (settings[s])
        begin
            write_min_bin(settings[s]);
            sent = 0;
            while (sent < RANDOM_ITEMS)
            begin
                if (settings[s] == MIN_BIN_RESET)
                    len = $urandom_range(55, 90);
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(25, 80);
                else
                    len = $urandom_range(1, 24);
                send_frame(len);
                sent += len;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            peak_out.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            peak_out.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            peak_out.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : peak_check
        peak_rec_t want;
        if (rst_n && peak_out.valid && peak_out.ready)
        begin
            if (expected_peaks.size() == 0)
            begin
                $error("unexpected peak item: peak_bin %0d peak_level %0d",
                       peak_out.peak_bin, peak_out.peak_level);
                mismatch_count++;
            end
            else
            begin
                want = expected_peaks.pop_front();
                if (peak_out.peak_bin !== want.bin)
                begin
                    $error("peak_bin: expected %0d, got %0d", want.bin, peak_out.peak_bin);
                    mismatch_count++;
                end
                if (peak_out.peak_level !== want.level)
                begin
                    $error("peak_level: expected %0d, got %0d",
                           want.level, peak_out.peak_level);
                    mismatch_count++;
                end
                if (peak_out.peak_last !== want.last)
                begin
                    $error("peak_last: expected %0d, got %0d", want.last, peak_out.peak_last);
                    mismatch_count++;
                end
            end
            stall_left = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        bin_in.valid     = 1'b0;
        bin_in.bin_real  = '0;
        bin_in.bin_imag  = '0;
        bin_in.frame_end = 1'b0;
        peak_out.ready   = 1'b0;
        send_burst       = 1'b0;
        sink_burst       = 1'b0;
        stall_left       = 0;
        mismatch_count   = 0;
        min_bin_now      = MIN_BIN_RESET;
        clear_frame_state();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_one_bin_frame();
        test_left_of_zero();
        test_extreme_values();
        test_ranking_and_ties();
        test_overlong_frame();
        test_random_frames();
        settle();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/spk_pkg.sv
hdl/spk_if.sv
hdl/spk_power.sv
hdl/spk_insert.sv
hdl/spectrum_top_peak_picker.sv
hdl/spk_checker.sv
tb/testbench.sv
